### design/jtdd_pkg.sv
// Shared types and constants for the joystick to differential drive mixer.
// No dependencies.
package jtdd_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int GUARD_BITS    = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_W      = 32;
    localparam int AXIS_W        = 16;
    localparam int FLOOR_W       = 15;
    localparam int MAG_W         = 15;
    localparam int ANGLE_W       = 31;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [ANGLE_W-1:0] ANGLE_90 = ANGLE_W'(1073741824);
    localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1 << FRAC_BITS);

    localparam int APB_ADDR_W = 3;
    localparam logic REG_MAG_FLOOR = 1'b0;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_FLIP  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    // atan(2^-i), 360 degrees = 2^32
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic       active;
        logic [1:0] command;
        logic       reverse;
    } side_t;

endpackage

### design/jtdd_if.sv
// Request channels of the mixer: joystick samples in, drive requests out.
// Depends on nothing.
interface jtdd_joy_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_axis;
    logic signed [15:0] y_axis;
    logic               safety_down;
    logic               flip_down;
    logic               reset_down;
    logic               start_down;

    modport source (output valid, x_axis, y_axis, safety_down, flip_down, reset_down,
                    start_down, input ready);
    modport sink (input valid, x_axis, y_axis, safety_down, flip_down, reset_down,
                  start_down, output ready);
endinterface

interface jtdd_drive_if;
    logic               valid;
    logic               ready;
    logic               active;
    logic [1:0]         command;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;

    modport source (output valid, active, command, left_drive, right_drive, input ready);
    modport sink (input valid, active, command, left_drive, right_drive, output ready);
endinterface

### design/jtdd_cordic.sv
// Pipelined vectoring CORDIC, one rotation per register stage.
// Depends on jtdd_pkg.
module jtdd_cordic
    import jtdd_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [CORDIC_W-1:0] in_x,
    input  logic signed [CORDIC_W-1:0] in_y,
    input  side_t                      in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [CORDIC_W-1:0] out_x,
    output logic signed [CORDIC_W-1:0] out_z,
    output side_t                      out_side
);

    logic signed [CORDIC_W-1:0] x_reg [STAGES];
    logic signed [CORDIC_W-1:0] y_reg [STAGES];
    logic signed [CORDIC_W-1:0] z_reg [STAGES];
    side_t                      side_reg [STAGES];
    logic [STAGES-1:0]          valid_reg;
    logic [STAGES:0]            rdy;

    assign rdy[STAGES] = out_ready;
    assign in_ready    = rdy[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
        logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
        logic signed [CORDIC_W-1:0] ang;
        side_t                      side_in;
        logic                       v_in;

        if (k == 0) begin : g_first
            assign x_in    = in_x;
            assign y_in    = in_y;
            assign z_in    = '0;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign x_in    = x_reg[k-1];
            assign y_in    = y_reg[k-1];
            assign z_in    = z_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        assign ang = $signed(ATAN_TAB[k]);
        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb
        begin
            if (!y_in[CORDIC_W-1]) begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + ang;
            end else begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k]) begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_z     = z_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

### design/joystick_to_differential_drive.sv
// Joystick to differential drive mixer, top level.
// Depends on jtdd_pkg, jtdd_if and jtdd_cordic.
//
// Usage:
//   joy   : joystick request in (valid/ready), X/Y in Q1.14 plus button levels.
//   drive : drive request out (valid/ready), active, command, left/right Q1.14.
//   APB   : register 0 (byte address 0) is magnitude_floor, 15 bits, Q1.14.
//           pready is always high; writes take effect at the access cycle.
// Every joystick request yields exactly one drive request, in order.
// The pipeline has one input stage, one stage per CORDIC rotation, then gain
// multiply, cap/floor, drive multiply and the output register. Throughput is
// one request per cycle while drive.ready is high.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// new requests are taken until every stage is full.
// Reset clears all valid bits and sets magnitude_floor to 0.
module joystick_to_differential_drive
    import jtdd_pkg::*;
#(
    parameter int CORDIC_STAGES_P = CORDIC_STAGES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    jtdd_joy_if.sink              joy,
    jtdd_drive_if.source          drive,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int GAIN_PROD_W = (CORDIC_W - 1) + 30;
    localparam int GAIN_SHIFT  = 30 + GUARD_BITS;
    localparam int R_W         = GAIN_PROD_W - GAIN_SHIFT;
    localparam int DPROD_W     = MAG_W + ANGLE_W;
    localparam int TERM_W      = DPROD_W - 29;
    localparam int SUM_W       = 18;

    // configuration
    logic [FLOOR_W-1:0] floor_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAG_FLOOR) ? 32'(floor_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            floor_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAG_FLOOR) begin
            floor_reg <= pwdata[FLOOR_W-1:0];
        end
    end

    // stage handshake
    logic p_valid_reg, g_valid_reg, m_valid_reg, d_valid_reg, o_valid_reg;
    logic en_p, en_g, en_m, en_d, en_o;
    logic c_in_ready, c_out_valid;

    assign en_o = !o_valid_reg || drive.ready;
    assign en_d = !d_valid_reg || en_o;
    assign en_m = !m_valid_reg || en_d;
    assign en_g = !g_valid_reg || en_m;
    assign en_p = !p_valid_reg || c_in_ready;
    assign joy.ready = en_p;

    // input stage: forward = -y, fold reverse, scale, pick command
    logic signed [CORDIC_W-1:0] p_x_reg, p_y_reg;
    side_t                      p_side_reg;
    logic signed [AXIS_W:0]     fwd;
    logic                       rev;
    logic [AXIS_W:0]            fwd_abs;
    side_t                      side_next;

    always_comb
    begin
        fwd     = -(AXIS_W+1)'(joy.y_axis);
        rev     = fwd[AXIS_W];
        fwd_abs = rev ? $unsigned(-fwd) : $unsigned(fwd);
        side_next.active  = joy.safety_down;
        side_next.reverse = rev;
        if (!joy.safety_down) begin
            side_next.command = CMD_NONE;
        end else if (joy.flip_down) begin
            side_next.command = CMD_FLIP;
        end else if (joy.reset_down) begin
            side_next.command = CMD_RESET;
        end else if (joy.start_down) begin
            side_next.command = CMD_START;
        end else begin
            side_next.command = CMD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_valid_reg <= 1'b0;
        end else if (en_p) begin
            p_valid_reg <= joy.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_p) begin
            p_x_reg    <= $signed(CORDIC_W'(fwd_abs)) <<< GUARD_BITS;
            p_y_reg    <= CORDIC_W'(joy.x_axis) <<< GUARD_BITS;
            p_side_reg <= side_next;
        end
    end

    // CORDIC
    logic signed [CORDIC_W-1:0] c_x, c_z;
    side_t                      c_side;

    jtdd_cordic #(
        .STAGES (CORDIC_STAGES_P)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid_reg),
        .in_ready  (c_in_ready),
        .in_x      (p_x_reg),
        .in_y      (p_y_reg),
        .in_side   (p_side_reg),
        .out_valid (c_out_valid),
        .out_ready (en_g),
        .out_x     (c_x),
        .out_z     (c_z),
        .out_side  (c_side)
    );

    // gain multiply
    logic [GAIN_PROD_W-1:0]     g_prod_reg;
    logic signed [CORDIC_W-1:0] g_z_reg;
    side_t                      g_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            g_valid_reg <= 1'b0;
        end else if (en_g) begin
            g_valid_reg <= c_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_g) begin
            g_prod_reg <= GAIN_PROD_W'(c_x[CORDIC_W-2:0]) * GAIN_PROD_W'(INV_GAIN_Q30);
            g_z_reg    <= c_z;
            g_side_reg <= c_side;
        end
    end

    // round radius, cap at 1.0, apply floor, fold angle
    logic [GAIN_PROD_W-1:0]  g_round;
    logic [R_W-1:0]          radius;
    logic [MAG_W-1:0]        mag_cap, mag_next;
    logic [CORDIC_W-1:0]     z_abs;
    logic [ANGLE_W-1:0]      ang_next;
    logic [MAG_W-1:0]        m_mag_reg;
    logic [ANGLE_W-1:0]      m_ang_reg;
    logic                    m_zpos_reg;
    side_t                   m_side_reg;

    always_comb
    begin
        g_round  = g_prod_reg + (GAIN_PROD_W'(1) << (GAIN_SHIFT - 1));
        radius   = g_round[GAIN_PROD_W-1:GAIN_SHIFT];
        mag_cap  = (radius > R_W'(MAG_ONE)) ? MAG_ONE : radius[MAG_W-1:0];
        mag_next = (FLOOR_W'(mag_cap) <= floor_reg) ? '0 : mag_cap;
        z_abs    = g_z_reg[CORDIC_W-1] ? $unsigned(-g_z_reg) : $unsigned(g_z_reg);
        ang_next = (z_abs > CORDIC_W'(ANGLE_90)) ? ANGLE_90 : z_abs[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
        end else if (en_m) begin
            m_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_m) begin
            m_mag_reg  <= mag_next;
            m_ang_reg  <= ang_next;
            m_zpos_reg <= !g_z_reg[CORDIC_W-1];
            m_side_reg <= g_side_reg;
        end
    end

    // drive multiply
    logic [DPROD_W-1:0] d_prod_reg;
    logic [MAG_W-1:0]   d_mag_reg;
    logic               d_zpos_reg;
    side_t              d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            d_valid_reg <= 1'b0;
        end else if (en_d) begin
            d_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d) begin
            d_prod_reg <= DPROD_W'(m_mag_reg) * DPROD_W'(m_ang_reg);
            d_mag_reg  <= m_mag_reg;
            d_zpos_reg <= m_zpos_reg;
            d_side_reg <= m_side_reg;
        end
    end

    // mix, reverse, saturate, zero when not active
    logic [DPROD_W-1:0]     d_round;
    logic [TERM_W-1:0]      term;
    logic signed [SUM_W-1:0] mag_s, lean, left_s, right_s;
    logic signed [15:0]     left_next, right_next;
    logic                   o_active_reg;
    logic [1:0]             o_command_reg;
    logic signed [15:0]     o_left_reg, o_right_reg;

    function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [15:0] res;
        if (v > SUM_W'(32767)) begin
            res = 16'sh7FFF;
        end else if (v < -SUM_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    always_comb
    begin
        d_round = d_prod_reg + (DPROD_W'(1) << 28);
        term    = d_round[DPROD_W-1:29];
        mag_s   = $signed(SUM_W'(d_mag_reg));
        lean    = mag_s - $signed(SUM_W'(term));
        left_s  = d_zpos_reg ? mag_s : lean;
        right_s = d_zpos_reg ? lean : mag_s;
        if (d_side_reg.reverse) begin
            left_s  = -left_s;
            right_s = -right_s;
        end
        if (d_side_reg.active) begin
            left_next  = sat16(left_s);
            right_next = sat16(right_s);
        end else begin
            left_next  = '0;
            right_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            o_valid_reg <= 1'b0;
        end else if (en_o) begin
            o_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o) begin
            o_active_reg  <= d_side_reg.active;
            o_command_reg <= d_side_reg.command;
            o_left_reg    <= left_next;
            o_right_reg   <= right_next;
        end
    end

    assign drive.valid       = o_valid_reg;
    assign drive.active      = o_active_reg;
    assign drive.command     = o_command_reg;
    assign drive.left_drive  = o_left_reg;
    assign drive.right_drive = o_right_reg;

endmodule
